FILE: design/ecpa_pkg.sv
// shared types, constants and modular helpers for the affine point adder
package ecpa_pkg;

  localparam int unsigned MAX_BITS = 64;

  typedef logic [MAX_BITS-1:0] word_t;

  // modulus after reset, before masking to the coordinate width
  localparam word_t MOD_RESET = 64'hFFFF_FFFF_FFFF_FFC5;

  // input beat: two affine points
  typedef struct packed {
    logic [63:0] p_x;
    logic [63:0] p_y;
    logic        p_inf;
    logic [63:0] q_x;
    logic [63:0] q_y;
    logic        q_inf;
  } in_t;

  // result beat: one affine point and the range flag
  typedef struct packed {
    logic [63:0] r_x;
    logic [63:0] r_y;
    logic        r_inf;
    logic        range_error;
  } out_t;

  // modular add, both operands below m
  function automatic word_t add_m(word_t a, word_t b, word_t m);
    word_t room;
    room = m - b;
    return (a >= room) ? a - room : a + b;
  endfunction

  // modular subtract, both operands below m
  function automatic word_t sub_m(word_t a, word_t b, word_t m);
    return (a >= b) ? a - b : a - b + m;
  endfunction

endpackage

FILE: design/ecpa_mod_mul.sv
// bit-serial modular multiplier, one bit of the multiplier per cycle
module ecpa_mod_mul #(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output logic         done,
  output logic [W-1:0] prod
);

  localparam int unsigned CW = $clog2(W);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  a_r, a_nxt;
  logic [W-1:0]  b_r, b_nxt;
  logic [W-1:0]  acc_r, acc_nxt;

  function automatic logic [W-1:0] madd(logic [W-1:0] x, logic [W-1:0] y);
    return W'(ecpa_pkg::add_m(64'(x), 64'(y), 64'(m)));
  endfunction

  // double and add, multiplier shifts out msb first
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    a_nxt    = a_r;
    b_nxt    = b_r;
    acc_nxt  = acc_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      a_nxt    = a;
      b_nxt    = b;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = madd(madd(acc_r, acc_r), b_r[W-1] ? a_r : '0);
      b_nxt   = {b_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == CW'(W-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

FILE: design/ecpa_mod_inv.sv
// modular inverse by extended euclid, quotient found one bit per cycle
module ecpa_mod_inv #(
  parameter int unsigned W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] a,
  input  logic [W-1:0] m,
  output logic         done,
  output logic         ok,
  output logic [W-1:0] inv
);

  localparam int unsigned KW = $clog2(W);

  typedef enum logic [4:0] {
    IV_IDLE  = 5'b00001,
    IV_TEST  = 5'b00010,
    IV_ALIGN = 5'b00100,
    IV_DESC  = 5'b01000,
    IV_UPD   = 5'b10000
  } iv_state_t;

  iv_state_t     state_r, state_nxt;
  logic          done_r, done_nxt;
  logic          ok_r, ok_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic [W-1:0]  r0_r, r0_nxt;
  logic [W-1:0]  r1_r, r1_nxt;
  logic [W-1:0]  t0_r, t0_nxt;
  logic [W-1:0]  t1_r, t1_nxt;
  logic [W-1:0]  d_r, d_nxt;
  logic [W-1:0]  acc_r, acc_nxt;
  logic          qbit;

  function automatic logic [W-1:0] madd(logic [W-1:0] x, logic [W-1:0] y);
    return W'(ecpa_pkg::add_m(64'(x), 64'(y), 64'(m)));
  endfunction

  function automatic logic [W-1:0] msub(logic [W-1:0] x, logic [W-1:0] y);
    return W'(ecpa_pkg::sub_m(64'(x), 64'(y), 64'(m)));
  endfunction

  assign qbit = (r0_r >= d_r);

  // euclid sequencer: align divisor, peel quotient bits, update cofactors
  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    ok_nxt    = ok_r;
    k_nxt     = k_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    t0_nxt    = t0_r;
    t1_nxt    = t1_r;
    d_nxt     = d_r;
    acc_nxt   = acc_r;
    unique case (state_r)
      IV_IDLE: begin
        if (start) begin
          r0_nxt    = m;
          r1_nxt    = a;
          t0_nxt    = '0;
          t1_nxt    = (m == W'(1)) ? '0 : W'(1);
          state_nxt = IV_TEST;
        end
      end
      IV_TEST: begin
        if (r1_r == '0) begin
          done_nxt  = 1'b1;
          ok_nxt    = (r0_r == W'(1));
          state_nxt = IV_IDLE;
        end else begin
          d_nxt     = r1_r;
          k_nxt     = '0;
          acc_nxt   = '0;
          state_nxt = IV_ALIGN;
        end
      end
      IV_ALIGN: begin
        if ({d_r, 1'b0} <= {1'b0, r0_r}) begin
          d_nxt = {d_r[W-2:0], 1'b0};
          k_nxt = k_r + KW'(1);
        end else begin
          state_nxt = IV_DESC;
        end
      end
      IV_DESC: begin
        if (qbit) begin
          r0_nxt = r0_r - d_r;
        end
        acc_nxt = madd(madd(acc_r, acc_r), qbit ? t1_r : '0);
        d_nxt   = {1'b0, d_r[W-1:1]};
        k_nxt   = k_r - KW'(1);
        if (k_r == '0) begin
          state_nxt = IV_UPD;
        end
      end
      IV_UPD: begin
        r0_nxt    = r1_r;
        r1_nxt    = r0_r;
        t0_nxt    = t1_r;
        t1_nxt    = msub(t0_r, acc_r);
        state_nxt = IV_TEST;
      end
      default: begin
        state_nxt = IV_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IV_IDLE;
      done_r  <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      ok_r    <= ok_nxt;
    end
    k_r   <= k_nxt;
    r0_r  <= r0_nxt;
    r1_r  <= r1_nxt;
    t0_r  <= t0_nxt;
    t1_r  <= t1_nxt;
    d_r   <= d_nxt;
    acc_r <= acc_nxt;
  end

  assign done = done_r;
  assign ok   = ok_r;
  assign inv  = t0_r;

endmodule

FILE: design/ec_affine_point_add.sv
// affine point addition on y^2 = x^3 + b modulo a configured odd prime
// one item at a time; pass-through and special cases go from the check straight to finish
// generic add: serial multiplies for the slope, its square and the y result, plus the inverse,
// which aligns the divisor and then peels the quotient bits in each euclid step
// doubling adds one more serial multiply, for the square of x
// synchronous active-low reset returns to idle and loads the default modulus
module ec_affine_point_add #(
  parameter int unsigned COORD_BITS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  ecpa_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output ecpa_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [63:0]     cfg_data
);

  localparam int unsigned W = COORD_BITS;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CHECK = 9'b000000010,
    ST_SQ    = 9'b000000100,
    ST_INV   = 9'b000001000,
    ST_SLOPE = 9'b000010000,
    ST_SSQ   = 9'b000100000,
    ST_RX    = 9'b001000000,
    ST_RY    = 9'b010000000,
    ST_FIN   = 9'b100000000
  } state_t;

  state_t         state_r, state_nxt;
  logic [W-1:0]   mod_r;
  logic [W-1:0]   px_r, py_r, qx_r, qy_r;
  logic           pinf_r, qinf_r, err_r;
  logic [W-1:0]   num_r, num_nxt;
  logic [W-1:0]   s_r, s_nxt;
  logic [W-1:0]   rx_r, rx_nxt;
  logic [W-1:0]   res_x_r, res_x_nxt;
  logic [W-1:0]   res_y_r, res_y_nxt;
  logic           res_inf_r, res_inf_nxt;
  logic           res_err_r, res_err_nxt;
  logic           out_valid_r, out_valid_nxt;
  ecpa_pkg::out_t out_data_r, out_data_nxt;
  logic           accept;
  logic           in_err;
  logic [63:0]    mod64;

  logic           mul_start, mul_done;
  logic [W-1:0]   mul_a, mul_b, mul_prod;
  logic           inv_start, inv_done, inv_ok;
  logic [W-1:0]   inv_a, inv_val;

  function automatic logic [W-1:0] madd(logic [W-1:0] x, logic [W-1:0] y);
    return W'(ecpa_pkg::add_m(64'(x), 64'(y), 64'(mod_r)));
  endfunction

  function automatic logic [W-1:0] msub(logic [W-1:0] x, logic [W-1:0] y);
    return W'(ecpa_pkg::sub_m(64'(x), 64'(y), 64'(mod_r)));
  endfunction

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign mod64     = 64'(mod_r);

  // range check on the full input width, infinite points exempt
  assign in_err = (!in_data.p_inf && (in_data.p_x >= mod64 || in_data.p_y >= mod64)) ||
                  (!in_data.q_inf && (in_data.q_x >= mod64 || in_data.q_y >= mod64));

  // modulus register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_r <= W'(ecpa_pkg::MOD_RESET);
    end else if (cfg_valid && cfg_ready) begin
      mod_r <= W'(cfg_data);
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (accept) begin
      px_r   <= W'(in_data.p_x);
      py_r   <= W'(in_data.p_y);
      qx_r   <= W'(in_data.q_x);
      qy_r   <= W'(in_data.q_y);
      pinf_r <= in_data.p_inf;
      qinf_r <= in_data.q_inf;
      err_r  <= in_err;
    end
  end

  // operand selection for the shared serial units
  always_comb begin
    mul_a = mul_prod;
    mul_b = mul_prod;
    unique case (state_r)
      ST_CHECK: begin
        mul_a = px_r;
        mul_b = px_r;
      end
      ST_INV: begin
        mul_a = num_r;
        mul_b = inv_val;
      end
      ST_RX: begin
        mul_a = s_r;
        mul_b = msub(px_r, rx_r);
      end
      default: begin
        mul_a = mul_prod;
        mul_b = mul_prod;
      end
    endcase
    inv_a = (state_r == ST_CHECK) ? msub(qx_r, px_r) : madd(py_r, py_r);
  end

  // point add sequencer
  always_comb begin
    state_nxt     = state_r;
    num_nxt       = num_r;
    s_nxt         = s_r;
    rx_nxt        = rx_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_inf_nxt   = res_inf_r;
    res_err_nxt   = res_err_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_start     = 1'b0;
    inv_start     = 1'b0;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        res_x_nxt   = '0;
        res_y_nxt   = '0;
        res_inf_nxt = 1'b0;
        res_err_nxt = 1'b0;
        if (err_r) begin
          res_inf_nxt = 1'b1;
          res_err_nxt = 1'b1;
          state_nxt   = ST_FIN;
        end else if (pinf_r) begin
          res_inf_nxt = qinf_r;
          res_x_nxt   = qinf_r ? '0 : qx_r;
          res_y_nxt   = qinf_r ? '0 : qy_r;
          state_nxt   = ST_FIN;
        end else if (qinf_r) begin
          res_x_nxt = px_r;
          res_y_nxt = py_r;
          state_nxt = ST_FIN;
        end else if (px_r == qx_r) begin
          if (py_r != qy_r || py_r == '0) begin
            res_inf_nxt = 1'b1;
            state_nxt   = ST_FIN;
          end else begin
            mul_start = 1'b1;
            state_nxt = ST_SQ;
          end
        end else begin
          num_nxt   = msub(qy_r, py_r);
          inv_start = 1'b1;
          state_nxt = ST_INV;
        end
      end
      ST_SQ: begin
        if (mul_done) begin
          num_nxt   = madd(madd(mul_prod, mul_prod), mul_prod);
          inv_start = 1'b1;
          state_nxt = ST_INV;
        end
      end
      ST_INV: begin
        if (inv_done) begin
          if (inv_ok) begin
            mul_start = 1'b1;
            state_nxt = ST_SLOPE;
          end else begin
            res_inf_nxt = 1'b1;
            state_nxt   = ST_FIN;
          end
        end
      end
      ST_SLOPE: begin
        if (mul_done) begin
          s_nxt     = mul_prod;
          mul_start = 1'b1;
          state_nxt = ST_SSQ;
        end
      end
      ST_SSQ: begin
        if (mul_done) begin
          rx_nxt    = msub(msub(mul_prod, px_r), qx_r);
          state_nxt = ST_RX;
        end
      end
      ST_RX: begin
        mul_start = 1'b1;
        state_nxt = ST_RY;
      end
      ST_RY: begin
        if (mul_done) begin
          res_x_nxt = rx_r;
          res_y_nxt = msub(mul_prod, py_r);
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.r_x         = 64'(res_x_r);
          out_data_nxt.r_y         = 64'(res_y_r);
          out_data_nxt.r_inf       = res_inf_r;
          out_data_nxt.range_error = res_err_r;
          state_nxt                = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r      <= num_nxt;
    s_r        <= s_nxt;
    rx_r       <= rx_nxt;
    res_x_r    <= res_x_nxt;
    res_y_r    <= res_y_nxt;
    res_inf_r  <= res_inf_nxt;
    res_err_r  <= res_err_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared serial multiplier
  ecpa_mod_mul #(
    .W (W)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .m     (mod_r),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  // slope denominator inverse
  ecpa_mod_inv #(
    .W (W)
  ) u_inv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (inv_start),
    .a     (inv_a),
    .m     (mod_r),
    .done  (inv_done),
    .ok    (inv_ok),
    .inv   (inv_val)
  );

endmodule

FILE: tb/sv/ec_affine_point_add_chk.sv
`timescale 1ns / 1ps
// checker for the point adder: predicts each result and compares it on the output channel
module ec_affine_point_add_chk (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_stall,
  input  ecpa_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_stall,
  input  ecpa_pkg::out_t out_data,
  input  logic           cfg_valid,
  input  logic           cfg_ready,
  input  logic [63:0]    cfg_data,
  output int             fail_count,
  output int             pending
);

  ecpa_pkg::word_t field_mod;
  ecpa_pkg::out_t  sums_q[$];

  function automatic ecpa_pkg::word_t madd(ecpa_pkg::word_t a, ecpa_pkg::word_t b,
                                           ecpa_pkg::word_t m);
    ecpa_pkg::word_t room;
    room = m - b;
    return (a >= room) ? a - room : a + b;
  endfunction

  function automatic ecpa_pkg::word_t msub(ecpa_pkg::word_t a, ecpa_pkg::word_t b,
                                           ecpa_pkg::word_t m);
    return (a >= b) ? a - b : a - b + m;
  endfunction

  function automatic ecpa_pkg::word_t mmul(ecpa_pkg::word_t a, ecpa_pkg::word_t b,
                                           ecpa_pkg::word_t m);
    ecpa_pkg::word_t acc;
    acc = '0;
    for (int i = 63; i >= 0; i--) begin
      acc = madd(acc, acc, m);
      if (b[i]) acc = madd(acc, a, m);
    end
    return acc;
  endfunction

  // extended euclid; returns 0 when no inverse exists
  function automatic bit minv(ecpa_pkg::word_t a, ecpa_pkg::word_t m,
                              output ecpa_pkg::word_t inv);
    ecpa_pkg::word_t r0, r1, r2, t0, t1, t2, qt;
    r0 = m; r1 = a; t0 = '0; t1 = 64'd1 % m; inv = '0;
    while (r1 != 0) begin
      qt = r0 / r1;
      r2 = r0 % r1;
      t2 = msub(t0, mmul(qt % m, t1, m), m);
      r0 = r1; r1 = r2; t0 = t1; t1 = t2;
    end
    if (r0 != 1) return 0;
    inv = t0;
    return 1;
  endfunction

  function automatic ecpa_pkg::out_t point_sum(ecpa_pkg::in_t pt, ecpa_pkg::word_t m);
    ecpa_pkg::out_t  r;
    ecpa_pkg::word_t num, den, dinv, s;
    bit              fin;
    r = '0;
    fin = 0;
    if ((!pt.p_inf && (pt.p_x >= m || pt.p_y >= m)) ||
        (!pt.q_inf && (pt.q_x >= m || pt.q_y >= m))) begin
      r.range_error = 1; r.r_inf = 1;
    end else if (pt.p_inf) begin
      r.r_inf = pt.q_inf;
      if (!pt.q_inf) begin r.r_x = pt.q_x; r.r_y = pt.q_y; end
    end else if (pt.q_inf) begin
      r.r_x = pt.p_x; r.r_y = pt.p_y;
    end else begin
      if (pt.p_x == pt.q_x) begin
        if (pt.p_y != pt.q_y || pt.p_y == 0) begin
          r.r_inf = 1; fin = 1;
        end else begin
          num = mmul(pt.p_x, pt.p_x, m);
          num = madd(madd(num, num, m), num, m);
          den = madd(pt.p_y, pt.p_y, m);
        end
      end else begin
        num = msub(pt.q_y, pt.p_y, m);
        den = msub(pt.q_x, pt.p_x, m);
      end
      if (!fin) begin
        if (!minv(den, m, dinv)) r.r_inf = 1;
        else begin
          s = mmul(num, dinv, m);
          r.r_x = msub(msub(mmul(s, s, m), pt.p_x, m), pt.q_x, m);
          r.r_y = msub(mmul(s, msub(pt.p_x, r.r_x, m), m), pt.p_y, m);
        end
      end
    end
    if (r.r_inf) begin r.r_x = '0; r.r_y = '0; end
    return r;
  endfunction

  assign pending = sums_q.size();

  // watch config, input and result beats
  always @(posedge clk) begin
    ecpa_pkg::out_t exp_sum;
    if (!rst_n) begin
      field_mod <= ecpa_pkg::MOD_RESET;
      fail_count <= 0;
      sums_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) field_mod <= cfg_data;
      if (in_valid && !in_stall) sums_q.push_back(point_sum(in_data, field_mod));
      if (out_valid && !out_stall) begin
        if (sums_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          exp_sum = sums_q.pop_front();
          if (exp_sum.r_x !== out_data.r_x || exp_sum.r_y !== out_data.r_y ||
              exp_sum.r_inf !== out_data.r_inf ||
              exp_sum.range_error !== out_data.range_error) begin
            $display("%0t: mismatch expected x=%h y=%h inf=%b rerr=%b", $time,
                     exp_sum.r_x, exp_sum.r_y, exp_sum.r_inf, exp_sum.range_error);
            $display("%0t:          actual   x=%h y=%h inf=%b rerr=%b", $time,
                     out_data.r_x, out_data.r_y, out_data.r_inf, out_data.range_error);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

FILE: tb/sv/ec_affine_point_add_tb.sv
`timescale 1ns / 1ps
// top of the point adder bench: clock, reset, stimulus and verdict
module ec_affine_point_add_tb;

  localparam ecpa_pkg::word_t P61 = 64'h1FFF_FFFF_FFFF_FFFF;

  logic            clk, rst_n;
  logic            in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  ecpa_pkg::in_t   in_data;
  ecpa_pkg::out_t  out_data;
  logic [63:0]     cfg_data;
  int              fail_count, pending;
  bit              hold_long;
  ecpa_pkg::word_t cur_mod;

  ec_affine_point_add uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  ec_affine_point_add_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) return 0;
    if (k < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver stalls of random length, with one long hold-off on request
  initial begin
    out_stall = 0;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1;
        repeat (3000) @(posedge clk);
        out_stall <= 0;
        hold_long = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1;
        repeat (gap_len() + 1) @(posedge clk);
        out_stall <= 0;
      end else out_stall <= 0;
    end
  end

  function automatic ecpa_pkg::word_t rcoord(ecpa_pkg::word_t m);
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return m;
    if (k == 1) return {$urandom, $urandom};
    if (k == 2) return m - 1;
    if (m == 0) return {$urandom, $urandom};
    return {$urandom, $urandom} % m;
  endfunction

  // offer one beat after an optional idle gap; valid stays up for a following beat
  task automatic send(ecpa_pkg::in_t item);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait until every accepted beat has come out
  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic drain_then_set(ecpa_pkg::word_t m);
    drain();
    repeat (1500) @(posedge clk);
    cfg_valid <= 1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    cur_mod = m;
  endtask

  task automatic random_items(int n);
    ecpa_pkg::in_t it;
    int            k;
    for (int i = 0; i < n; i++) begin
      it.p_x = rcoord(cur_mod); it.p_y = rcoord(cur_mod);
      it.q_x = rcoord(cur_mod); it.q_y = rcoord(cur_mod);
      it.p_inf = ($urandom_range(0, 9) == 0);
      it.q_inf = ($urandom_range(0, 9) == 0);
      k = $urandom_range(0, 9);
      if (k == 0) begin it.q_x = it.p_x; it.q_y = it.p_y; end
      else if (k == 1) it.q_x = it.p_x;
      send(it);
    end
  endtask

  // stimulus
  initial begin
    ecpa_pkg::in_t   it;
    ecpa_pkg::word_t m;
    hold_long = 0;
    rst_n = 0; in_valid = 0; in_data = '0; cfg_valid = 0; cfg_data = '0;
    cur_mod = ecpa_pkg::MOD_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    m = cur_mod;
    // directed: infinities, doubling, vertical, y zero, range, extremes
    it = '{p_x:5, p_y:7, p_inf:1, q_x:3, q_y:4, q_inf:0}; send(it);
    it = '{p_x:5, p_y:7, p_inf:0, q_x:m, q_y:4, q_inf:1}; send(it);
    it = '{p_x:m, p_y:m, p_inf:1, q_x:'1, q_y:'1, q_inf:1}; send(it);
    it = '{p_x:5, p_y:7, p_inf:0, q_x:5, q_y:7, q_inf:0}; send(it);
    it = '{p_x:5, p_y:7, p_inf:0, q_x:5, q_y:9, q_inf:0}; send(it);
    it = '{p_x:5, p_y:0, p_inf:0, q_x:5, q_y:0, q_inf:0}; send(it);
    it = '{p_x:m, p_y:1, p_inf:0, q_x:2, q_y:3, q_inf:0}; send(it);
    it = '{p_x:1, p_y:1, p_inf:0, q_x:2, q_y:'1, q_inf:0}; send(it);
    it = '{p_x:0, p_y:0, p_inf:0, q_x:m-1, q_y:m-1, q_inf:0}; send(it);
    it = '{p_x:m-1, p_y:m-1, p_inf:0, q_x:m-1, q_y:m-1, q_inf:0}; send(it);
    it = '{p_x:'1, p_y:'1, p_inf:0, q_x:0, q_y:0, q_inf:1}; send(it);
    // long receiver hold-off while items keep coming
    hold_long = 1;
    random_items(12);
    random_items(300);
    drain_then_set(P61);
    random_items(120);
    drain_then_set(64'd15);
    random_items(60);
    drain_then_set(64'd1);
    random_items(20);
    drain_then_set(64'd0);
    random_items(20);
    drain_then_set(64'd3);
    random_items(40);
    drain_then_set(64'hFFFF_FFFF_FFFF_FFFF);
    random_items(60);
    drain_then_set(64'd1000003);
    random_items(60);
    drain();
    repeat (1500) @(posedge clk);
    if (fail_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #200ms;
    $display("simulation failed");
    $finish;
  end
endmodule
